// File: sv/isort_pkg.sv
// Shared types and constants for the integer sorter.
package isort_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic load;   // insert the broadcast item
    logic drain;  // shift toward the output end
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } sort_state_t;

endpackage

// File: sv/isort_cell.sv
// One cell of the insertion chain: holds one element and its valid bit.
module isort_cell
  import isort_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic                     left_valid,
  input  logic                     left_keep,
  input  logic signed [DATA_W-1:0] right_value,
  input  logic                     right_valid,
  output logic signed [DATA_W-1:0] value,
  output logic                     valid,
  output logic                     keep
);

  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     valid_r, valid_nxt;

  // Held element stays put when it is not above the new one.
  assign keep = valid_r && (value_r <= new_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.load) begin
      if (!keep) begin
        if (left_keep) begin
          value_nxt = new_value;
          valid_nxt = 1'b1;
        end else begin
          value_nxt = left_value;
          valid_nxt = left_valid;
        end
      end
    end else if (ctrl.drain) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// File: sv/integer_sorter.sv
// Integer sorter: a set of signed 32-bit items loads one per cycle into a chain of DEPTH
// insertion cells, each of which compares the arriving item with its own element and
// keeps it, takes the new one or takes its left neighbor's, so the chain is always in
// ascending order. Loading proceeds while in_tready is high. The item
// with in_tlast closes the set; the chain then shifts toward the output and presents one
// sorted item per cycle while out_tready is high; no input is accepted meanwhile.
// Items arriving while all DEPTH cells are full are dropped and the final result carries
// out_tuser = 1. Throughput is set by the single chain: load and drain do not overlap.
module integer_sorter
  import isort_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic              out_tlast,
  output logic              out_tuser   // [0] truncated
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  sort_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  cell_ctrl_t       ctrl;
  logic             in_acc, out_acc, full;

  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic                     cell_valid [DEPTH];
  logic                     cell_keep  [DEPTH];

  assign full    = (count_r == CNT_W'(DEPTH));
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign ctrl.load  = in_acc && !full;
  assign ctrl.drain = out_acc;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] l_value, r_value;
      logic                     l_valid, l_keep, r_valid;
      if (gi == 0) begin : g_head
        assign l_value = $signed(in_tdata);
        assign l_valid = 1'b1;
        assign l_keep  = 1'b1;
      end else begin : g_body
        assign l_value = cell_value[gi-1];
        assign l_valid = cell_valid[gi-1];
        assign l_keep  = cell_keep[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign r_value = '0;
        assign r_valid = 1'b0;
      end else begin : g_mid
        assign r_value = cell_value[gi+1];
        assign r_valid = cell_valid[gi+1];
      end
      isort_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_value  ($signed(in_tdata)),
        .left_value (l_value),
        .left_valid (l_valid),
        .left_keep  (l_keep),
        .right_value(r_value),
        .right_valid(r_valid),
        .value      (cell_value[gi]),
        .valid      (cell_valid[gi]),
        .keep       (cell_keep[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_DRAIN);
  assign out_tdata  = cell_value[0];
  assign out_tlast  = out_tvalid && (count_r == CNT_W'(1));
  assign out_tuser  = out_tlast && ovf_r;

endmodule

// File: sv/isort_checker.sv
// Port-level checks for the integer sorter, bound to the top level.
module isort_checker
  import isort_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic              out_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_trunc_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("truncation flag off the final result");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("load and drain overlap");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && ($signed($past(out_tdata)) <= $signed(out_tdata))))
    else $error("results not ascending");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block did not return to loading");

endmodule

bind integer_sorter isort_checker u_isort_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
